[hw/rtl/phmm_pkg.sv]
// Shared types, constants and tables of the pair-HMM forward scorer.
package phmm_pkg;

    // Log values: signed fixed point, LOG_FRAC_BITS fraction bits
    localparam int LOG_W         = 24;
    localparam int LOG_FRAC_BITS = 8;
    localparam int PROB_BITS     = 16;
    localparam int PROB_KW       = $clog2(PROB_BITS);
    localparam int MAX_HAP_LEN   = 1024;
    localparam int HAP_AW        = $clog2(MAX_HAP_LEN);
    localparam int LEN_W         = HAP_AW + 1;
    localparam int SYM_W         = 3;
    localparam int N_CFG         = 8;
    localparam int CFG_IW        = $clog2(N_CFG);
    localparam int PADDR_W       = CFG_IW + 2;
    localparam int PDATA_W       = 32;

    // Softplus table index starts at this bit of the difference
    localparam int SP_IDX_LSB    = LOG_FRAC_BITS - 2;
    localparam int SP_IDX_W      = 5;
    localparam int SCALE_SH      = 16 - LOG_FRAC_BITS;

    typedef logic signed [LOG_W-1:0] t_log;
    typedef logic signed [LOG_W:0]   t_wide;

    localparam t_log LOG_FLOOR = {1'b1, {(LOG_W-1){1'b0}}};
    localparam t_log LOG_CEIL  = {1'b0, {(LOG_W-1){1'b1}}};

    localparam logic [SYM_W-1:0] SYM_OTHER = 3'd4;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_TMM  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_TIM  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TDM  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TMI  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TII  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_TMD  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_TDD  = 3'd6;
    localparam logic [CFG_IW-1:0] REG_INIT = 3'd7;

    // ln(0.1) magnitude in Q16, ln 2 in Q30
    localparam logic [17:0] LN_TENTH_Q16 = 18'd150902;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;

    typedef enum logic {
        LOP_ADD,   // product in log space
        LOP_SUM    // sum in log space
    } t_log_op;

    typedef struct packed {
        logic              req_type;
        logic              hap_first;
        logic [SYM_W-1:0]  hap_symbol;
        logic [15:0]       prob_a;
        logic [15:0]       prob_c;
        logic [15:0]       prob_g;
        logic [15:0]       prob_t;
        logic              row_last;
    } t_in;

    typedef struct packed {
        t_log log_likelihood;
        logic is_floor;
    } t_out;

    // Q16 magnitude rounded to LOG_FRAC_BITS
    function automatic t_log scale16(input logic [17:0] q);
        logic [18:0] r;
        r = {1'b0, q} + (19'(1) << (SCALE_SH - 1));
        return t_log'(r >> SCALE_SH);
    endfunction

    // ln(1+exp(-x)) at x = (k+0.5)/4, Q16
    function automatic logic [17:0] softplus_q16(input logic [SP_IDX_W-1:0] k);
        logic [17:0] v;
        case (k)
            5'd0:  v = 18'd41458;  5'd1:  v = 18'd34284;
            5'd2:  v = 18'd28095;  5'd3:  v = 18'd22836;
            5'd4:  v = 18'd18425;  5'd5:  v = 18'd14773;
            5'd6:  v = 18'd11780;  5'd7:  v = 18'd9350;
            5'd8:  v = 18'd7394;   5'd9:  v = 18'd5829;
            5'd10: v = 18'd4583;   5'd11: v = 18'd3597;
            5'd12: v = 18'd2818;   5'd13: v = 18'd2205;
            5'd14: v = 18'd1724;   5'd15: v = 18'd1346;
            5'd16: v = 18'd1051;   5'd17: v = 18'd820;
            5'd18: v = 18'd639;    5'd19: v = 18'd498;
            5'd20: v = 18'd389;    5'd21: v = 18'd303;
            5'd22: v = 18'd236;    5'd23: v = 18'd184;
            5'd24: v = 18'd143;    5'd25: v = 18'd112;
            5'd26: v = 18'd87;     5'd27: v = 18'd68;
            5'd28: v = 18'd53;     5'd29: v = 18'd41;
            5'd30: v = 18'd32;     5'd31: v = 18'd25;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    // Match emission magnitudes in Q16: ln 0.9, ln 0.8, ln 0.9, ln 0.7
    function automatic logic [17:0] match_emit_q16(input logic [1:0] b);
        logic [17:0] v;
        case (b)
            2'd0:    v = 18'd6905;
            2'd1:    v = 18'd14624;
            2'd2:    v = 18'd6905;
            2'd3:    v = 18'd23375;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    // Saturate a widened log value
    function automatic t_log sat_log(input t_wide v);
        t_log r;
        if (v <= t_wide'(LOG_FLOOR))     r = LOG_FLOOR;
        else if (v > t_wide'(LOG_CEIL))  r = LOG_CEIL;
        else                             r = v[LOG_W-1:0];
        return r;
    endfunction

endpackage

[hw/rtl/pair_hmm_forward_log.sv]
// Top level of the log-space pair-HMM forward scorer.
// Usage:
//  Input beats (i_in_valid / o_in_stall) carry either a haplotype symbol load
//  (req_type 0, hap_first restarts the haplotype) or a read row with four base
//  probabilities (req_type 1). A row with row_last set produces one output beat
//  (o_out_valid / i_out_stall) with the log-likelihood and a floor flag.
//  Registers are to be written over the APB port while the block is idle; the
//  block itself does not enforce this. A read row first takes the log of each
//  nonzero probability (a zero one is skipped) for the log and emission terms,
//  then sweeps the haplotype columns: per column, one column read of the row
//  memory and 13 steps of the single shared log unit; the last row adds two
//  accumulation steps per column. The result is registered in the output
//  register after the row finishes. The log of each probability uses one
//  shared 31x31 multiplier for 20 squaring steps plus the final scale by ln 2.
//  o_in_stall is high for the whole of a row. A finished result waits in the
//  output register while the next beat is accepted; a second result waits
//  until the first is taken. After reset the haplotype is empty and no read
//  is open; no memory clearing pass is needed.
module pair_hmm_forward_log import phmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int M_W       = 31;
    localparam int M_FRAC    = 30;
    localparam int SH_W      = 5;
    localparam int PROD_W    = 2 * M_W;
    localparam int LN_FRAC   = 20;
    localparam int MAG_W     = 25;
    localparam int LN_SH     = M_FRAC + LN_FRAC - LOG_FRAC_BITS;
    localparam int CNT_W     = 5;
    localparam int N_EM      = 5;

    localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(LN_FRAC - 1);
    localparam logic [CNT_W-1:0] EM_LAST = 5'd11;
    localparam logic [2:0]       EM_INS  = 3'd5;

    // Column step sequence
    localparam logic [CNT_W-1:0] CS_MM  = 5'd0;
    localparam logic [CNT_W-1:0] CS_IM  = 5'd1;
    localparam logic [CNT_W-1:0] CS_S1  = 5'd2;
    localparam logic [CNT_W-1:0] CS_DM  = 5'd3;
    localparam logic [CNT_W-1:0] CS_S2  = 5'd4;
    localparam logic [CNT_W-1:0] CS_NM  = 5'd5;
    localparam logic [CNT_W-1:0] CS_MI  = 5'd6;
    localparam logic [CNT_W-1:0] CS_II  = 5'd7;
    localparam logic [CNT_W-1:0] CS_S3  = 5'd8;
    localparam logic [CNT_W-1:0] CS_NI  = 5'd9;
    localparam logic [CNT_W-1:0] CS_MD  = 5'd10;
    localparam logic [CNT_W-1:0] CS_DD  = 5'd11;
    localparam logic [CNT_W-1:0] CS_ND  = 5'd12;
    localparam logic [CNT_W-1:0] CS_CS  = 5'd13;
    localparam logic [CNT_W-1:0] CS_ACC = 5'd14;

    typedef struct packed {
        t_log m;
        t_log i;
        t_log d;
    } t_cell;

    typedef enum logic [3:0] {
        S_IDLE, S_LNP_INIT, S_LNP_SQ, S_LNP_MUL, S_LNP_RND, S_EM,
        S_COL_START, S_COL_RD, S_COL_OP, S_DONE
    } t_state;

    t_state                r_state;
    t_log                  r_cfg [N_CFG];
    logic                  r_open, r_fresh, r_last;
    logic [LEN_W-1:0]      r_len, r_col;
    logic [1:0]            r_base;
    logic [CNT_W-1:0]      r_cnt;
    logic [PROB_BITS-1:0]  r_prob [4];
    logic [M_W-1:0]        r_m;
    logic [PROB_KW-1:0]    r_k;
    logic [LN_FRAC-1:0]    r_frac;
    logic [PROD_W-1:0]     r_prod;
    t_log                  r_lnp, r_t0, r_t1, r_ei, r_total;
    t_log                  r_em [N_EM];
    t_log                  r_om, r_oi, r_od, r_cm, r_cd, r_nm, r_ni;
    logic                  r_out_valid;
    t_out                  r_out;

    // Memories
    t_cell                 r_rows [MAX_HAP_LEN];
    logic [SYM_W-1:0]      r_hap  [MAX_HAP_LEN];
    t_cell                 r_rd_row;
    logic [SYM_W-1:0]      r_hap_rd;

    logic                  w_in_acc, w_cfg_we;
    logic [LEN_W-1:0]      w_load_len;
    logic                  w_hap_we;
    logic [SYM_W-1:0]      w_sym_clamp;
    logic [HAP_AW-1:0]     w_col_addr;
    logic [PROB_BITS-1:0]  w_p;
    logic [PROB_KW-1:0]    w_k;
    logic [M_W-1:0]        w_m0, w_mul_a, w_mul_b, w_m_sq;
    logic [PROD_W-1:0]     w_prod, w_rnd;
    logic [M_W:0]          w_sq_sh;
    logic [MAG_W-1:0]      w_mag;
    t_log                  w_lnp, w_emit, w_em_rd, w_pm, w_pi, w_pd;
    logic [2:0]            w_h, w_em_idx;
    logic [SYM_W-1:0]      w_sym_idx;
    t_log_op               w_op;
    t_log                  w_a, w_b, w_res;
    logic [CNT_W-1:0]      w_col_end;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign w_cfg_we    = psel && penable && pwrite;
    assign prdata      = {{(PDATA_W-LOG_W){r_cfg[paddr[PADDR_W-1:2]][LOG_W-1]}},
                          r_cfg[paddr[PADDR_W-1:2]]};

    // Symbol load address and clamp
    assign w_load_len  = i_in.hap_first ? '0 : r_len;
    assign w_hap_we    = w_in_acc && !i_in.req_type && (w_load_len < LEN_W'(MAX_HAP_LEN));
    assign w_sym_clamp = (i_in.hap_symbol > SYM_OTHER) ? SYM_OTHER : i_in.hap_symbol;
    assign w_col_addr  = HAP_AW'(r_col - LEN_W'(1));

    // Log of one probability: normalize, square 20 times, scale by ln 2
    always_comb begin
        w_p = r_prob[r_base];
        w_k = '0;
        for (int b = 0; b < PROB_BITS; b++) begin
            if (w_p[b]) w_k = PROB_KW'(b);
        end
        w_m0    = M_W'(w_p) << (SH_W'(M_FRAC) - SH_W'(w_k));
        w_mag   = ((MAG_W'(PROB_BITS) - MAG_W'(r_k)) << LN_FRAC) - MAG_W'(r_frac);
        w_mul_a = (r_state == S_LNP_MUL) ? M_W'(w_mag) : r_m;
        w_mul_b = (r_state == S_LNP_MUL) ? M_W'(LN2_Q30) : r_m;
        w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        w_sq_sh = w_prod[PROD_W-1:M_FRAC];
        w_m_sq  = w_sq_sh[M_W] ? w_sq_sh[M_W:1] : w_sq_sh[M_W-1:0];
        w_rnd   = r_prod + (PROD_W'(1) << (LN_SH - 1));
        w_lnp   = t_log'(0) - t_log'(w_rnd[PROD_W-1:LN_SH]);
    end

    // Operand selection for the shared log unit
    always_comb begin
        w_h       = r_cnt[3:1];
        w_sym_idx = (r_hap_rd > SYM_OTHER) ? SYM_OTHER : r_hap_rd;
        w_em_idx  = (r_state == S_EM) ? w_h : w_sym_idx;
        w_em_rd   = (w_em_idx < 3'(N_EM)) ? r_em[w_em_idx] : LOG_FLOOR;
        w_pm      = r_fresh ? LOG_FLOOR : r_rd_row.m;
        w_pi      = r_fresh ? LOG_FLOOR : r_rd_row.i;
        w_pd      = r_fresh ? r_cfg[REG_INIT] : r_rd_row.d;
        w_col_end = r_last ? CS_ACC : CS_ND;

        if (w_h == EM_INS)
            w_emit = t_log'(0) - scale16(LN_TENTH_Q16);
        else if (w_h == {1'b0, r_base})
            w_emit = t_log'(0) - scale16(match_emit_q16(r_base));
        else
            w_emit = '0;

        w_op = LOP_ADD;
        w_a  = LOG_FLOOR;
        w_b  = LOG_FLOOR;
        if (r_state == S_EM) begin
            if (!r_cnt[0]) begin
                w_a = r_lnp;
                w_b = w_emit;
            end else begin
                w_op = LOP_SUM;
                w_a  = (w_h == EM_INS) ? r_ei : w_em_rd;
                w_b  = r_t0;
            end
        end else begin
            case (r_cnt)
                CS_MM:  begin w_a = r_om;    w_b = r_cfg[REG_TMM]; end
                CS_IM:  begin w_a = r_oi;    w_b = r_cfg[REG_TIM]; end
                CS_S1:  begin w_op = LOP_SUM; w_a = r_t0; w_b = r_t1; end
                CS_DM:  begin w_a = r_od;    w_b = r_cfg[REG_TDM]; end
                CS_S2:  begin w_op = LOP_SUM; w_a = r_t0; w_b = r_t1; end
                CS_NM:  begin w_a = w_em_rd; w_b = r_t0; end
                CS_MI:  begin w_a = w_pm;    w_b = r_cfg[REG_TMI]; end
                CS_II:  begin w_a = w_pi;    w_b = r_cfg[REG_TII]; end
                CS_S3:  begin w_op = LOP_SUM; w_a = r_t0; w_b = r_t1; end
                CS_NI:  begin w_a = r_ei;    w_b = r_t0; end
                CS_MD:  begin w_a = r_cm;    w_b = r_cfg[REG_TMD]; end
                CS_DD:  begin w_a = r_cd;    w_b = r_cfg[REG_TDD]; end
                CS_ND:  begin w_op = LOP_SUM; w_a = r_t0; w_b = r_t1; end
                CS_CS:  begin w_op = LOP_SUM; w_a = r_nm; w_b = r_ni; end
                CS_ACC: begin w_op = LOP_SUM; w_a = r_total; w_b = r_t1; end
                default: begin w_a = LOG_FLOOR; w_b = LOG_FLOOR; end
            endcase
        end
    end

    phmm_logu u_logu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    // Haplotype memory
    always_ff @(posedge i_clk) begin
        if (w_hap_we) begin
            r_hap[w_load_len[HAP_AW-1:0]] <= w_sym_clamp;
        end
        if (r_state == S_COL_RD) begin
            r_hap_rd <= r_hap[w_col_addr];
        end
    end

    // Row memory: match, insert and delete of every column
    always_ff @(posedge i_clk) begin
        if (r_state == S_COL_OP && r_cnt == CS_ND) begin
            r_rows[w_col_addr] <= '{m: r_nm, i: r_ni, d: w_res};
        end
        if (r_state == S_COL_RD) begin
            r_rd_row <= r_rows[w_col_addr];
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_open            <= 1'b0;
            r_len             <= '0;
            r_out_valid       <= 1'b0;
            r_cfg[REG_TMM]    <= -24'sd27;
            r_cfg[REG_TIM]    <= -24'sd589;
            r_cfg[REG_TDM]    <= -24'sd589;
            r_cfg[REG_TMI]    <= -24'sd589;
            r_cfg[REG_TII]    <= -24'sd57;
            r_cfg[REG_TMD]    <= LOG_FLOOR;
            r_cfg[REG_TDD]    <= -24'sd27;
            r_cfg[REG_INIT]   <= -24'sd1774;
        end else begin
            if (w_cfg_we) begin
                r_cfg[paddr[PADDR_W-1:2]] <= t_log'(pwdata[LOG_W-1:0]);
            end
            // a taken result clears unless a new one replaces it this cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (!i_in.req_type) begin
                            // symbol load abandons any open read
                            r_open <= 1'b0;
                            r_len  <= w_hap_we ? w_load_len + LEN_W'(1) : w_load_len;
                        end else begin
                            r_prob[0] <= i_in.prob_a[PROB_BITS-1:0];
                            r_prob[1] <= i_in.prob_c[PROB_BITS-1:0];
                            r_prob[2] <= i_in.prob_g[PROB_BITS-1:0];
                            r_prob[3] <= i_in.prob_t[PROB_BITS-1:0];
                            r_last    <= i_in.row_last;
                            r_fresh   <= !r_open;
                            r_open    <= 1'b1;
                            r_base    <= '0;
                            r_ei      <= LOG_FLOOR;
                            for (int h = 0; h < N_EM; h++) r_em[h] <= LOG_FLOOR;
                            r_state   <= S_LNP_INIT;
                        end
                    end
                end

                S_LNP_INIT: begin
                    if (w_p == '0) begin
                        if (r_base == 2'd3) r_state <= S_COL_START;
                        else                r_base  <= r_base + 2'd1;
                    end else begin
                        r_m     <= w_m0;
                        r_k     <= w_k;
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_LNP_SQ;
                    end
                end

                S_LNP_SQ: begin
                    r_m    <= w_m_sq;
                    r_frac <= {r_frac[LN_FRAC-2:0], w_sq_sh[M_W]};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == SQ_LAST) r_state <= S_LNP_MUL;
                end

                S_LNP_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_LNP_RND;
                end

                S_LNP_RND: begin
                    r_lnp   <= w_lnp;
                    r_cnt   <= '0;
                    r_state <= S_EM;
                end

                // Fold this base into the five match emissions and the insert one
                S_EM: begin
                    if (!r_cnt[0])             r_t0           <= w_res;
                    else if (w_h == EM_INS)    r_ei           <= w_res;
                    else                       r_em[w_em_idx] <= w_res;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == EM_LAST) begin
                        if (r_base == 2'd3) begin
                            r_state <= S_COL_START;
                        end else begin
                            r_base  <= r_base + 2'd1;
                            r_state <= S_LNP_INIT;
                        end
                    end
                end

                // Column 0 reads as the opening values on a fresh read, else log-zero
                S_COL_START: begin
                    r_om    <= LOG_FLOOR;
                    r_oi    <= LOG_FLOOR;
                    r_od    <= r_fresh ? r_cfg[REG_INIT] : LOG_FLOOR;
                    r_cm    <= LOG_FLOOR;
                    r_cd    <= LOG_FLOOR;
                    r_total <= LOG_FLOOR;
                    r_col   <= LEN_W'(1);
                    if (r_len == '0) begin
                        if (r_last) begin
                            r_open  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_COL_RD;
                    end
                end

                S_COL_RD: begin
                    r_cnt   <= '0;
                    r_state <= S_COL_OP;
                end

                S_COL_OP: begin
                    case (r_cnt)
                        CS_MM, CS_S1, CS_S2, CS_MI, CS_S3, CS_MD: r_t0 <= w_res;
                        CS_IM, CS_DM, CS_II, CS_DD, CS_CS:        r_t1 <= w_res;
                        CS_NM:  r_nm    <= w_res;
                        CS_NI:  r_ni    <= w_res;
                        CS_ACC: r_total <= w_res;
                        CS_ND: begin
                            // shift the column window
                            r_cd <= w_res;
                            r_cm <= r_nm;
                            r_om <= w_pm;
                            r_oi <= w_pi;
                            r_od <= w_pd;
                        end
                        default: r_t0 <= r_t0;
                    endcase
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == w_col_end) begin
                        if (r_col == r_len) begin
                            if (r_last) begin
                                r_open  <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_col   <= r_col + LEN_W'(1);
                            r_state <= S_COL_RD;
                        end
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.log_likelihood <= r_total;
                        r_out.is_floor       <= (r_total == LOG_FLOOR);
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/phmm_logu.sv]
// Shared log-space unit: log product (saturating add) and log sum (max plus softplus).
module phmm_logu import phmm_pkg::*; (
    input  t_log_op i_op,
    input  t_log    i_a,
    input  t_log    i_b,
    output t_log    o_res
);

    t_log  w_hi, w_lo, w_add;
    t_wide w_diff, w_asum, w_lsum;

    always_comb begin
        w_hi   = (i_a > i_b) ? i_a : i_b;
        w_lo   = (i_a > i_b) ? i_b : i_a;
        w_diff = t_wide'(w_hi) - t_wide'(w_lo);
        // softplus is zero once the difference passes the table
        w_add  = '0;
        if (w_diff[LOG_W:SP_IDX_LSB+SP_IDX_W] == '0) begin
            w_add = scale16(softplus_q16(w_diff[SP_IDX_LSB+SP_IDX_W-1:SP_IDX_LSB]));
        end
        w_lsum = t_wide'(w_hi) + t_wide'(w_add);
        w_asum = t_wide'(i_a) + t_wide'(i_b);

        // log-zero absorbs a product and drops out of a sum
        case (i_op)
            LOP_ADD: begin
                if (i_a == LOG_FLOOR || i_b == LOG_FLOOR) o_res = LOG_FLOOR;
                else                                      o_res = sat_log(w_asum);
            end
            LOP_SUM: begin
                if (i_a == LOG_FLOOR)      o_res = i_b;
                else if (i_b == LOG_FLOOR) o_res = i_a;
                else                       o_res = sat_log(w_lsum);
            end
            default: o_res = LOG_FLOOR;
        endcase
    end

endmodule

[hw/rtl/phmm_check.sv]
// Port-level checker of the pair-HMM forward scorer and its bind.
module phmm_check import phmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  t_in                i_in,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  t_out               o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    // Floor flag agrees with the value
    a_floor_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_floor == (o_out.log_likelihood == LOG_FLOOR)))
        else $error("floor flag mismatch");

    // A read row keeps the block busy
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.req_type |=> o_in_stall)
        else $error("read row did not hold input stall");

    // A new result only comes out of work in progress
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a read row");

endmodule

bind pair_hmm_forward_log phmm_check u_phmm_check (.*);
